// ===== sv/sbag_pkg.sv =====
// ---------------------------------------------------------------------------
// sbag_pkg: shared types and constants of the scaled blit address generator
// Holds the fixed field widths, register indexes and the controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package sbag_pkg;

    // Fixed widths of the geometry fields.
    localparam int DIM_BITS    = 12;
    localparam int ACC_BITS    = DIM_BITS + 1;
    localparam int SCREEN_BITS = 13;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = SCREEN_BITS'(320);
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = SCREEN_BITS'(200);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } cfg_index_t;

    // Input operation codes.
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_COL  = 3'b010,
        ST_ROW  = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_start;
        logic load_step;
        logic col_iter;
        logic row_iter;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_start;
        logic col_adv;
        logic row_adv;
        logic col_more;
        logic row_more;
    } status_t;

endpackage

// ===== sv/sbag_ctrl.sv =====
// ---------------------------------------------------------------------------
// sbag_ctrl: controller of the scaled blit address generator
// Sequences input acceptance, the accumulator subtract loops and the output
// register handshake.
// ---------------------------------------------------------------------------
module sbag_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  sbag_pkg::status_t  status,
    output sbag_pkg::cmd_t     cmd
);

    sbag_pkg::state_t state_reg;
    sbag_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;

    // A step needs a free output slot; a start gives no result.
    assign in_ready = (state_reg == sbag_pkg::ST_IDLE) &&
                      (status.op_start || !out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd.load_start = accept && status.op_start;
        cmd.load_step  = accept && !status.op_start;
        cmd.col_iter   = (state_reg == sbag_pkg::ST_COL) && status.col_more;
        cmd.row_iter   = (state_reg == sbag_pkg::ST_ROW) && status.row_more;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbag_pkg::ST_IDLE:
            begin
                if (cmd.load_step && status.col_adv)
                    state_next = sbag_pkg::ST_COL;
                else if (cmd.load_step && status.row_adv)
                    state_next = sbag_pkg::ST_ROW;
            end
            sbag_pkg::ST_COL:
            begin
                if (!status.col_more)
                    state_next = sbag_pkg::ST_IDLE;
            end
            sbag_pkg::ST_ROW:
            begin
                if (!status.row_more)
                    state_next = sbag_pkg::ST_IDLE;
            end
            default:
                state_next = sbag_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbag_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/sbag_datapath.sv =====
// ---------------------------------------------------------------------------
// sbag_datapath: datapath of the scaled blit address generator
// Holds the latched geometry, the position and accumulator registers, the
// screen size registers and the output payload register.
// ---------------------------------------------------------------------------
module sbag_datapath
#(
    parameter int COORD_BITS = 13,
    parameter int ADDR_BITS  = 24
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [0:0]                            cfg_index,
    input  logic [sbag_pkg::SCREEN_BITS-1:0]      cfg_data,
    input  logic                                  in_operation,
    input  logic [COORD_BITS-1:0]                 in_dest_x,
    input  logic [COORD_BITS-1:0]                 in_dest_y,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_dest_w,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_dest_h,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_src_x,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_src_y,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_src_w,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_src_h,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_image_width,
    input  logic [sbag_pkg::DIM_BITS-1:0]         in_image_height,
    input  sbag_pkg::cmd_t                        cmd,
    output sbag_pkg::status_t                     status,
    output logic                                  out_active,
    output logic [COORD_BITS:0]                   out_screen_x,
    output logic [COORD_BITS:0]                   out_screen_y,
    output logic [ADDR_BITS-1:0]                  out_source_address,
    output logic                                  out_visible,
    output logic                                  out_last
);

    localparam int DW  = sbag_pkg::DIM_BITS;
    localparam int AW  = sbag_pkg::ACC_BITS;
    localparam int SB  = sbag_pkg::SCREEN_BITS;
    // Internal coordinate width: holds corner plus size without overflow.
    localparam int XW  = ((COORD_BITS > DW + 1) ? COORD_BITS : DW + 1) + 2;
    // Source column width: wide enough for a 12-bit start column.
    localparam int SCW = (COORD_BITS > DW) ? COORD_BITS : DW;

    // Screen size registers.
    logic [SB-1:0]          scr_w_reg;
    logic [SB-1:0]          scr_h_reg;

    // Latched geometry.
    logic [COORD_BITS-1:0]  dx_reg;
    logic [COORD_BITS-1:0]  dy_reg;
    logic [DW-1:0]          dw_reg;
    logic [DW-1:0]          dh_reg;
    logic [DW-1:0]          sx_reg;
    logic [DW-1:0]          sw_reg;
    logic [DW-1:0]          sh_reg;
    logic [DW-1:0]          iw_reg;

    // Walk state.
    logic                   busy_reg;
    logic signed [XW-1:0]   cur_x_reg;
    logic signed [XW-1:0]   cur_y_reg;
    logic [SCW-1:0]         src_col_reg;
    logic [ADDR_BITS-1:0]   row_base_reg;
    logic [AW-1:0]          col_acc_reg;
    logic [AW-1:0]          row_acc_reg;

    // Output payload.
    logic                   o_active_reg;
    logic [COORD_BITS:0]    o_x_reg;
    logic [COORD_BITS:0]    o_y_reg;
    logic [ADDR_BITS-1:0]   o_addr_reg;
    logic                   o_visible_reg;
    logic                   o_last_reg;

    // Start decode.
    logic [DW-1:0]          sw_def;
    logic [DW-1:0]          sh_def;
    logic [DW-1:0]          dw_def;
    logic [DW-1:0]          dh_def;
    logic signed [XW-1:0]   in_dx_ext;
    logic signed [XW-1:0]   in_dy_ext;
    logic signed [XW-1:0]   scr_w_ext;
    logic signed [XW-1:0]   scr_h_ext;
    logic [2*DW-1:0]        start_prod;
    logic                   start_live;

    // Step decode.
    logic signed [XW-1:0]   dx_ext;
    logic signed [XW-1:0]   dy_ext;
    logic signed [XW-1:0]   x_end;
    logic signed [XW-1:0]   y_end;
    logic signed [XW-1:0]   nx;
    logic signed [XW-1:0]   ny;
    logic                   row_done;
    logic                   blit_done;
    logic                   on_screen;

    always_comb
    begin
        sw_def    = (in_src_w == '0) ? in_image_width : in_src_w;
        sh_def    = (in_src_h == '0) ? in_image_height : in_src_h;
        dw_def    = (in_dest_w == '0) ? sw_def : in_dest_w;
        dh_def    = (in_dest_h == '0) ? sh_def : in_dest_h;
        in_dx_ext = {{(XW-COORD_BITS){in_dest_x[COORD_BITS-1]}}, in_dest_x};
        in_dy_ext = {{(XW-COORD_BITS){in_dest_y[COORD_BITS-1]}}, in_dest_y};
        scr_w_ext = {{(XW-SB){1'b0}}, scr_w_reg};
        scr_h_ext = {{(XW-SB){1'b0}}, scr_h_reg};
        start_prod = in_src_y * in_image_width;
        start_live = !(dw_def == '0 || dh_def == '0 ||
                       in_dx_ext >= scr_w_ext || in_dy_ext >= scr_h_ext);
    end

    always_comb
    begin
        dx_ext    = {{(XW-COORD_BITS){dx_reg[COORD_BITS-1]}}, dx_reg};
        dy_ext    = {{(XW-COORD_BITS){dy_reg[COORD_BITS-1]}}, dy_reg};
        x_end     = dx_ext + {{(XW-DW){1'b0}}, dw_reg};
        y_end     = dy_ext + {{(XW-DW){1'b0}}, dh_reg};
        nx        = cur_x_reg + XW'(1);
        ny        = cur_y_reg + XW'(1);
        row_done  = (nx >= x_end) || (nx >= scr_w_ext);
        blit_done = (ny >= y_end) || (ny >= scr_h_ext);
        on_screen = (cur_x_reg >= 0) && (cur_y_reg >= 0) &&
                    (cur_x_reg < scr_w_ext) && (cur_y_reg < scr_h_ext);
    end

    always_comb
    begin
        status.op_start = (in_operation == sbag_pkg::OP_START);
        status.col_adv  = busy_reg && !row_done;
        status.row_adv  = busy_reg && row_done && !blit_done;
        status.col_more = (col_acc_reg >= {1'b0, dw_reg});
        status.row_more = (row_acc_reg >= {1'b0, dh_reg});
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= sbag_pkg::SCREEN_WIDTH_RESET;
            scr_h_reg <= sbag_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbag_pkg::REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                sbag_pkg::REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                default:                     scr_w_reg <= scr_w_reg;
            endcase
        end
    end

    // Walk state and geometry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            dx_reg       <= '0;
            dy_reg       <= '0;
            dw_reg       <= '0;
            dh_reg       <= '0;
            sx_reg       <= '0;
            sw_reg       <= '0;
            sh_reg       <= '0;
            iw_reg       <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            src_col_reg  <= '0;
            row_base_reg <= '0;
            col_acc_reg  <= '0;
            row_acc_reg  <= '0;
        end
        else if (cmd.load_start)
        begin
            dx_reg       <= in_dest_x;
            dy_reg       <= in_dest_y;
            dw_reg       <= dw_def;
            dh_reg       <= dh_def;
            sx_reg       <= in_src_x;
            sw_reg       <= sw_def;
            sh_reg       <= sh_def;
            iw_reg       <= in_image_width;
            cur_x_reg    <= in_dx_ext;
            cur_y_reg    <= in_dy_ext;
            src_col_reg  <= SCW'(in_src_x);
            col_acc_reg  <= '0;
            row_acc_reg  <= '0;
            row_base_reg <= ADDR_BITS'(start_prod);
            busy_reg     <= start_live;
        end
        else if (cmd.load_step)
        begin
            if (status.col_adv)
            begin
                // Column advance: the source column wraps at COORD_BITS.
                col_acc_reg <= col_acc_reg + {1'b0, sw_reg};
                src_col_reg <= SCW'(src_col_reg[COORD_BITS-1:0]);
                cur_x_reg   <= nx;
            end
            else if (status.row_adv)
            begin
                row_acc_reg <= row_acc_reg + {1'b0, sh_reg};
                cur_y_reg   <= ny;
                cur_x_reg   <= dx_ext;
                src_col_reg <= SCW'(sx_reg);
                col_acc_reg <= '0;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
        else if (cmd.col_iter)
        begin
            col_acc_reg <= col_acc_reg - {1'b0, dw_reg};
            src_col_reg <= SCW'(src_col_reg[COORD_BITS-1:0] + COORD_BITS'(1));
        end
        else if (cmd.row_iter)
        begin
            row_acc_reg  <= row_acc_reg - {1'b0, dh_reg};
            row_base_reg <= row_base_reg + ADDR_BITS'(iw_reg);
        end
    end

    // Output payload register; an idle step reads all zeros.
    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
        begin
            if (busy_reg)
            begin
                o_active_reg  <= 1'b1;
                o_x_reg       <= cur_x_reg[COORD_BITS:0];
                o_y_reg       <= cur_y_reg[COORD_BITS:0];
                o_addr_reg    <= row_base_reg + ADDR_BITS'(src_col_reg);
                o_visible_reg <= on_screen;
                o_last_reg    <= row_done && blit_done;
            end
            else
            begin
                o_active_reg  <= 1'b0;
                o_x_reg       <= '0;
                o_y_reg       <= '0;
                o_addr_reg    <= '0;
                o_visible_reg <= 1'b0;
                o_last_reg    <= 1'b0;
            end
        end
    end

    assign out_active         = o_active_reg;
    assign out_screen_x       = o_x_reg;
    assign out_screen_y       = o_y_reg;
    assign out_source_address = o_addr_reg;
    assign out_visible        = o_visible_reg;
    assign out_last           = o_last_reg;

endmodule

// ===== sv/scaled_blit_address_generator.sv =====
// ---------------------------------------------------------------------------
// scaled_blit_address_generator: nearest-neighbor scaled blit walker
// Walks the destination rectangle of a scaled blit in raster order and
// gives the screen coordinate, the source pixel address and a visible flag.
// ---------------------------------------------------------------------------
// A step result is in the output register the cycle after its transaction;
// a start gives no result. After a column or row step the controller runs
// the accumulator subtract loop, one subtraction per cycle, and takes no new
// item until it has left the loop; a start, an idle step or a final step
// runs no loop. A step also waits for a free output slot. Reset: idle,
// screen 320 by 200, no result.
// ---------------------------------------------------------------------------
module scaled_blit_address_generator
#(
    parameter int COORD_BITS = 13,
    parameter int ADDR_BITS  = 24
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [0:0]                             cfg_index,
    input  logic [sbag_pkg::SCREEN_BITS-1:0]       cfg_data,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata, from bit 0: dest_x, dest_y, dest_w, dest_h, src_x, src_y,
    // src_w, src_h, image_width, image_height, zero fill.
    input  logic [((2*COORD_BITS+8*sbag_pkg::DIM_BITS+7)/8)*8-1:0]
                                                   s_tdata,
    // s_tuser: operation.
    input  logic                                   s_tuser,
    // Output stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata, from bit 0: screen_x, screen_y, source_address, zero fill.
    output logic [((2*(COORD_BITS+1)+ADDR_BITS+7)/8)*8-1:0]
                                                   m_tdata,
    // m_tuser, from bit 0: active, visible.
    output logic [1:0]                             m_tuser,
    output logic                                   m_tlast
);

    localparam int D        = sbag_pkg::DIM_BITS;
    localparam int OUT_BITS = 2*(COORD_BITS+1) + ADDR_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Bit offsets of the input fields inside s_tdata.
    localparam int OFS_DY = COORD_BITS;
    localparam int OFS_DW = 2*COORD_BITS;
    localparam int OFS_DH = OFS_DW + D;
    localparam int OFS_SX = OFS_DH + D;
    localparam int OFS_SY = OFS_SX + D;
    localparam int OFS_SW = OFS_SY + D;
    localparam int OFS_SH = OFS_SW + D;
    localparam int OFS_IW = OFS_SH + D;
    localparam int OFS_IH = OFS_IW + D;

    sbag_pkg::cmd_t            cmd;
    sbag_pkg::status_t         status;
    logic                      out_active;
    logic [COORD_BITS:0]       out_screen_x;
    logic [COORD_BITS:0]       out_screen_y;
    logic [ADDR_BITS-1:0]      out_source_address;
    logic                      out_visible;
    logic                      out_last;

    // Configuration writes are always taken; they must only be issued while the
    // block is idle, as the block has no interlock that enforces it.
    assign cfg_ready = 1'b1;

    // The controller owns the stream handshakes and sequences the subtract loops
    // that carry the nearest-neighbor error accumulators past each step.
    sbag_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the geometry, the walk position and the result
    // register that parts the output side from the input side.
    sbag_datapath
    #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    )
    u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_operation       (s_tuser),
        .in_dest_x          (s_tdata[COORD_BITS-1:0]),
        .in_dest_y          (s_tdata[OFS_DY +: COORD_BITS]),
        .in_dest_w          (s_tdata[OFS_DW +: D]),
        .in_dest_h          (s_tdata[OFS_DH +: D]),
        .in_src_x           (s_tdata[OFS_SX +: D]),
        .in_src_y           (s_tdata[OFS_SY +: D]),
        .in_src_w           (s_tdata[OFS_SW +: D]),
        .in_src_h           (s_tdata[OFS_SH +: D]),
        .in_image_width     (s_tdata[OFS_IW +: D]),
        .in_image_height    (s_tdata[OFS_IH +: D]),
        .cmd                (cmd),
        .status             (status),
        .out_active         (out_active),
        .out_screen_x       (out_screen_x),
        .out_screen_y       (out_screen_y),
        .out_source_address (out_source_address),
        .out_visible        (out_visible),
        .out_last           (out_last)
    );

    // Pack the result; the fill bits above the address read as zero.
    assign m_tdata = OUT_W'({out_source_address, out_screen_y, out_screen_x});
    assign m_tuser = {out_visible, out_active};
    assign m_tlast = out_last;

endmodule

// ===== sv/sbag_checker.sv =====
// ---------------------------------------------------------------------------
// sbag_checker: port-level checks for the scaled blit address generator
// Watches the output stream of the top level and is bound to it below.
// ---------------------------------------------------------------------------
module sbag_checker
#(
    parameter int COORD_BITS = 13,
    parameter int ADDR_BITS  = 24
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           m_tvalid,
    input  logic                                           m_tready,
    input  logic [((2*(COORD_BITS+1)+ADDR_BITS+7)/8)*8-1:0] m_tdata,
    input  logic [1:0]                                     m_tuser,
    input  logic                                           m_tlast
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output result changed while stalled");

    // A step taken while idle gives an all-zero result.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1] && !m_tlast)
        else $error("inactive result carries nonzero fields");

    // Visible and last positions belong to a blit in progress.
    a_flags_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1] || m_tlast) |-> m_tuser[0])
        else $error("visible or last set on an inactive result");

    // A visible position has nonnegative screen coordinates.
    a_visible_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tdata[COORD_BITS] && !m_tdata[2*COORD_BITS+1])
        else $error("visible result with a negative coordinate");

endmodule

bind scaled_blit_address_generator sbag_checker
#(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
)
u_sbag_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/scaled_blit_address_generator_tb.sv =====
// ---------------------------------------------------------------------------
// scaled_blit_address_generator_tb: self-checking bench for the blit walker
// Drives start and step transactions into the scaled blit address generator
// and predicts every step result with a behavioral model of the walk: the
// defaulted geometry, the nearest-neighbor column and row accumulators, row
// clipping at the screen width and blit end at the screen height or the last
// destination row. Each result is compared field by field in arrival order.
// Both stream sides idle at random; the screen registers are rewritten
// between phases, including in the middle of a blit.
// ---------------------------------------------------------------------------
module scaled_blit_address_generator_tb;

    localparam int RANDOM_ITEMS   = 650;
    localparam int WATCHDOG_LIMIT = 100000;

    // Input fields as they sit on s_tdata, listed from the top bit down so
    // that dest_x lands in bit 0. 122 field bits, zero-filled to 16 bytes.
    typedef struct packed {
        logic [5:0]         fill;
        logic [11:0]        image_height;
        logic [11:0]        image_width;
        logic [11:0]        src_h;
        logic [11:0]        src_w;
        logic [11:0]        src_y;
        logic [11:0]        src_x;
        logic [11:0]        dest_h;
        logic [11:0]        dest_w;
        logic signed [12:0] dest_y;
        logic signed [12:0] dest_x;
    } blit_fields_t;

    // One predicted step result.
    typedef struct {
        logic        active;
        logic [13:0] screen_x;
        logic [13:0] screen_y;
        logic [23:0] source_address;
        logic        visible;
        logic        last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                 cfg_valid;
    logic                 cfg_ready;
    sbag_pkg::cfg_index_t cfg_index;
    logic [12:0]          cfg_data;

    logic         s_tvalid;
    logic         s_tready;
    // s_tdata, from bit 0: dest_x, dest_y, dest_w, dest_h, src_x, src_y,
    // src_w, src_h, image_width, image_height, zero fill.
    blit_fields_t s_tdata;
    // s_tuser: operation.
    sbag_pkg::op_t s_tuser;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata, from bit 0: screen_x, screen_y, source_address, zero fill.
    logic [55:0] m_tdata;
    // m_tuser, from bit 0: active, visible.
    logic [1:0]  m_tuser;
    logic        m_tlast;

    scaled_blit_address_generator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Bench-side copy of the walker. It is only touched by the stimulus
    // process, at the clock edge where a transaction is accepted, so the
    // expected results are queued before the block can produce them.
    // -----------------------------------------------------------------------
    logic [12:0] scr_w = sbag_pkg::SCREEN_WIDTH_RESET;
    logic [12:0] scr_h = sbag_pkg::SCREEN_HEIGHT_RESET;

    bit          blit_busy = 1'b0;
    int          cur_x = 0;
    int          cur_y = 0;
    logic [12:0] src_col = '0;
    logic [23:0] row_base = '0;
    int          col_err = 0;
    int          row_err = 0;

    // Latched geometry after the zero-size defaults have been applied.
    int geo_dx = 0;
    int geo_dy = 0;
    int geo_dw = 0;
    int geo_dh = 0;
    int geo_sx = 0;
    int geo_sw = 0;
    int geo_sh = 0;
    int geo_iw = 0;

    // Worst number of cycles one step of the current blit can keep the block
    // busy: the accumulator loop runs about src/dest times per position.
    int step_cost = 8;

    pixel_t expected_pixels[$];
    int     errors     = 0;
    int     items_sent = 0;
    bit     no_idle    = 1'b0;

    function automatic void advance_blit_walk(input sbag_pkg::op_t op,
                                              input blit_fields_t f);
        pixel_t px;
        int     ih;
        int     acc;
        int     nx;
        int     ny;
        bit     fin;

        if (op == sbag_pkg::OP_START)
        begin
            geo_iw = f.image_width;
            ih     = f.image_height;
            geo_dx = int'(f.dest_x);
            geo_dy = int'(f.dest_y);
            geo_sx = f.src_x;
            geo_sw = (f.src_w == 0) ? geo_iw : int'(f.src_w);
            geo_sh = (f.src_h == 0) ? ih : int'(f.src_h);
            geo_dw = (f.dest_w == 0) ? geo_sw : int'(f.dest_w);
            geo_dh = (f.dest_h == 0) ? geo_sh : int'(f.dest_h);

            // A new start always replaces whatever blit was running.
            cur_x    = geo_dx;
            cur_y    = geo_dy;
            src_col  = 13'(geo_sx);
            col_err  = 0;
            row_err  = 0;
            row_base = 24'(int'(f.src_y) * geo_iw);
            blit_busy = !(geo_dw == 0 || geo_dh == 0 ||
                          geo_dx >= int'(scr_w) || geo_dy >= int'(scr_h));
            step_cost = (geo_dw != 0 && geo_dh != 0) ?
                        geo_sw / geo_dw + geo_sh / geo_dh + 8 : 8;
            return;
        end

        // A step while idle gives a result with every field cleared.
        px = '{default: '0};
        if (blit_busy)
        begin
            px.active         = 1'b1;
            px.screen_x       = 14'(cur_x);
            px.screen_y       = 14'(cur_y);
            px.source_address = 24'(src_col + row_base);
            px.visible        = cur_x >= 0 && cur_y >= 0 &&
                                cur_x < int'(scr_w) && cur_y < int'(scr_h);
            fin = 1'b0;
            nx  = cur_x + 1;
            if (nx < geo_dx + geo_dw && nx < int'(scr_w))
            begin
                // Next column: carry whole source pixels out of the error sum.
                acc     = col_err + geo_sw;
                src_col = 13'(src_col + acc / geo_dw);
                col_err = acc % geo_dw;
                cur_x   = nx;
            end
            else
            begin
                // The row is done, either by its width or by the screen edge.
                ny = cur_y + 1;
                if (ny >= geo_dy + geo_dh || ny >= int'(scr_h))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    acc      = row_err + geo_sh;
                    row_base = 24'(row_base + (acc / geo_dh) * geo_iw);
                    row_err  = acc % geo_dh;
                    cur_y    = ny;
                    cur_x    = geo_dx;
                    src_col  = 13'(geo_sx);
                    col_err  = 0;
                end
            end
            px.last = fin;
            if (fin)
            begin
                blit_busy = 1'b0;
            end
        end
        expected_pixels.push_back(px);
    endfunction

    // -----------------------------------------------------------------------
    // Result side: random back-pressure and the in-order comparison.
    // -----------------------------------------------------------------------
    function automatic void compare_field(input string name, input logic [23:0] want,
                                          input logic [23:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("result transaction with no step waiting for it");
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                compare_field("active", 24'(want.active), 24'(m_tuser[0]));
                compare_field("screen_x", 24'(want.screen_x), 24'(m_tdata[13:0]));
                compare_field("screen_y", 24'(want.screen_y), 24'(m_tdata[27:14]));
                compare_field("source_address", want.source_address, m_tdata[51:28]);
                compare_field("visible", 24'(want.visible), 24'(m_tuser[1]));
                compare_field("last", 24'(want.last), 24'(m_tlast));
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= 36);
    end

    // The watchdog restarts whenever any channel moves a transaction. The
    // slowest legal quiet stretch is the pause before a register write after
    // heavy downscaling.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers.
    // -----------------------------------------------------------------------
    task automatic issue_blit_item(input sbag_pkg::op_t op, input blit_fields_t fields);
        if (!no_idle)
        begin
            while ($urandom_range(99) < 36)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= fields;
        do @(posedge clk); while (!s_tready);
        advance_blit_walk(op, fields);
        items_sent++;
    endtask

    // Holds the input off until every queued result has been seen. Always
    // waits on the clock before it returns, so valid is never lowered and
    // raised in the same step.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_pixels.size() != 0);
    endtask

    task automatic write_screen_reg(input sbag_pkg::cfg_index_t idx, input int value);
        wait_results_drained();
        // A start or the accumulator loop of the last step may still be busy.
        repeat (step_cost) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sbag_pkg::REG_SCREEN_WIDTH)
        begin
            scr_w = 13'(value);
        end
        else
        begin
            scr_h = 13'(value);
        end
    endtask

    function automatic blit_fields_t random_fields();
        blit_fields_t f;
        f.fill         = '0;
        f.dest_x       = 13'($urandom);
        f.dest_y       = 13'($urandom);
        f.dest_w       = 12'($urandom);
        f.dest_h       = 12'($urandom);
        f.src_x        = 12'($urandom);
        f.src_y        = 12'($urandom);
        f.src_w        = 12'($urandom);
        f.src_h        = 12'($urandom);
        f.image_width  = 12'($urandom_range(1, 4095));
        f.image_height = 12'($urandom_range(1, 4095));
        return f;
    endfunction

    function automatic blit_fields_t blit_geometry(input int dx, input int dy,
                                                   input int dw, input int dh,
                                                   input int sx, input int sy,
                                                   input int sw, input int sh,
                                                   input int iw, input int ih);
        blit_fields_t f;
        f.fill         = '0;
        f.dest_x       = 13'(dx);
        f.dest_y       = 13'(dy);
        f.dest_w       = 12'(dw);
        f.dest_h       = 12'(dh);
        f.src_x        = 12'(sx);
        f.src_y        = 12'(sy);
        f.src_w        = 12'(sw);
        f.src_h        = 12'(sh);
        f.image_width  = 12'(iw);
        f.image_height = 12'(ih);
        return f;
    endfunction

    // Steps the current blit until it ends or the step budget runs out.
    task automatic step_blit(input int max_steps);
        for (int i = 0; i < max_steps && blit_busy; i++)
        begin
            issue_blit_item(sbag_pkg::OP_STEP, random_fields());
        end
    endtask

    // Mostly small sizes so that blits run to their end; now and then a
    // full-range size, including zero for the defaults.
    function automatic int pick_extent();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            return $urandom_range(0, 4095);
        end
        if (roll < 25)
        begin
            return $urandom_range(0, 20);
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic int pick_screen_size();
        case ($urandom_range(5))
            0:       return 1;
            1:       return 4096;
            2:       return 320;
            3:       return $urandom_range(1, 4096);
            default: return $urandom_range(8, 64);
        endcase
    endfunction

    // One start with random geometry and the steps that follow it. A wild
    // start keeps the fully random fields; otherwise the corner is placed
    // near the screen edges and the sizes are kept mostly small.
    task automatic run_random_blit(input bit wild);
        blit_fields_t f;
        int           pick;
        int           budget;

        f = random_fields();
        if (!wild)
        begin
            pick = $urandom_range(9);
            if (pick >= 2 && pick <= 3)
                f.dest_x = 13'(int'(scr_w) - int'($urandom_range(1, 6)));
            else if (pick == 4)
                f.dest_x = 13'(-int'($urandom_range(1, 6)));
            else if (pick >= 5)
                f.dest_x = 13'($urandom_range(0, 24));
            pick = $urandom_range(9);
            if (pick >= 2 && pick <= 3)
                f.dest_y = 13'(int'(scr_h) - int'($urandom_range(1, 6)));
            else if (pick == 4)
                f.dest_y = 13'(-int'($urandom_range(1, 6)));
            else if (pick >= 5)
                f.dest_y = 13'($urandom_range(0, 24));
            f.dest_w = 12'(pick_extent());
            f.dest_h = 12'(pick_extent());
            f.src_w  = 12'(pick_extent());
            f.src_h  = 12'(pick_extent());
            if ($urandom_range(1) == 1)
            begin
                f.image_width  = 12'($urandom_range(1, 12));
                f.image_height = 12'($urandom_range(1, 12));
            end
        end
        issue_blit_item(sbag_pkg::OP_START, f);

        // Heavy downscaling makes every step slow, so such blits get at most three
        // steps before the next start drops them.
        budget = (step_cost > 72) ? 3 : 60;
        if ($urandom_range(99) < 15)
        begin
            budget = $urandom_range(1, budget);
        end
        step_blit(budget);
        if (!blit_busy && $urandom_range(99) < 20)
        begin
            issue_blit_item(sbag_pkg::OP_STEP, random_fields());
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests.
    // -----------------------------------------------------------------------

    // Steps with no blit running give inactive, all-zero results.
    task automatic test_idle_steps();
        repeat (2) issue_blit_item(sbag_pkg::OP_STEP, random_fields());
    endtask

    // Zero sizes take the image size for the source and the source size for
    // the destination.
    task automatic test_default_sizes();
        issue_blit_item(sbag_pkg::OP_START, blit_geometry(0, 0, 0, 0, 1, 1, 0, 0, 2, 2));
        step_blit(8);
        issue_blit_item(sbag_pkg::OP_START, blit_geometry(5, 3, 0, 1, 0, 0, 2, 0, 7, 4));
        step_blit(8);
    endtask

    // Empty blit, negative corner, restart in the middle of a blit with the
    // largest source values, and clipping at the right and bottom edges.
    task automatic test_clipping_and_restart();
        issue_blit_item(sbag_pkg::OP_START,
                        blit_geometry(4095, 0, 2, 2, 0, 0, 2, 2, 4, 4));
        issue_blit_item(sbag_pkg::OP_STEP, random_fields());
        issue_blit_item(sbag_pkg::OP_START,
                        blit_geometry(-4096, -1, 2, 2, 0, 0, 4, 4, 9, 9));
        step_blit(2);
        // The address wraps at 24 bits once the second row is reached.
        issue_blit_item(sbag_pkg::OP_START,
                        blit_geometry(0, 0, 1, 2, 4095, 4095, 4095, 4095, 4095, 1));
        step_blit(4);
        issue_blit_item(sbag_pkg::OP_START,
                        blit_geometry(318, 198, 4, 4, 0, 0, 2, 2, 16, 16));
        step_blit(8);
    endtask

    // Smallest and largest screens, and screen changes in the middle of a
    // blit, where the new size decides the next row end and visibility.
    task automatic test_register_changes();
        write_screen_reg(sbag_pkg::REG_SCREEN_WIDTH, 1);
        write_screen_reg(sbag_pkg::REG_SCREEN_HEIGHT, 1);
        issue_blit_item(sbag_pkg::OP_START, blit_geometry(0, 0, 3, 3, 0, 0, 3, 3, 8, 8));
        step_blit(4);

        write_screen_reg(sbag_pkg::REG_SCREEN_WIDTH, 4096);
        write_screen_reg(sbag_pkg::REG_SCREEN_HEIGHT, 4096);
        issue_blit_item(sbag_pkg::OP_START,
                        blit_geometry(4090, 4093, 8, 5, 0, 0, 8, 5, 64, 64));
        step_blit(30);

        issue_blit_item(sbag_pkg::OP_START, blit_geometry(0, 0, 4, 4, 0, 0, 4, 4, 8, 8));
        step_blit(2);
        write_screen_reg(sbag_pkg::REG_SCREEN_WIDTH, 2);
        step_blit(1);
        write_screen_reg(sbag_pkg::REG_SCREEN_HEIGHT, 1);
        step_blit(10);

        write_screen_reg(sbag_pkg::REG_SCREEN_WIDTH, 320);
        write_screen_reg(sbag_pkg::REG_SCREEN_HEIGHT, 200);
    endtask

    // Random blits in phases, with new screen sizes every few phases, a long
    // stretch without idling on either side, and full pauses until every
    // result is back.
    task automatic test_random_blits();
        int phase;
        int roll;

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (phase % 4 == 3)
            begin
                write_screen_reg(sbag_pkg::REG_SCREEN_WIDTH, pick_screen_size());
                write_screen_reg(sbag_pkg::REG_SCREEN_HEIGHT, pick_screen_size());
            end
            no_idle = (phase >= 6 && phase < 12);
            repeat (4)
            begin
                roll = $urandom_range(99);
                if (roll < 82)
                begin
                    run_random_blit(1'b0);
                end
                else if (roll < 90)
                begin
                    run_random_blit(1'b1);
                end
                else
                begin
                    repeat ($urandom_range(1, 3))
                        issue_blit_item(sbag_pkg::OP_STEP, random_fields());
                end
            end
            if (phase % 5 == 2)
            begin
                wait_results_drained();
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= sbag_pkg::REG_SCREEN_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= sbag_pkg::OP_STEP;
        s_tdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_steps();
        test_default_sizes();
        test_clipping_and_restart();
        test_register_changes();
        test_random_blits();

        // Let the last results come back, then give the block time to
        // finish any accumulator loop before the verdict.
        wait_results_drained();
        repeat (step_cost) @(posedge clk);
        if (errors == 0 && expected_pixels.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sbag_pkg.sv
sv/sbag_ctrl.sv
sv/sbag_datapath.sv
sv/scaled_blit_address_generator.sv
sv/sbag_checker.sv
bench/scaled_blit_address_generator_tb.sv
